@@ design/adaptive_delta_step_size_assert.svh @@
// assertion macros for the adaptive delta step size block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef ADAPTIVE_DELTA_STEP_SIZE_ASSERT_SVH
`define ADAPTIVE_DELTA_STEP_SIZE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ADS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ADS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/ads_pkg.sv @@
// shared types and constants for the adaptive delta step size block
// no dependencies
`default_nettype none

package ads_pkg;

  localparam int unsigned WINDOW_LENGTH = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  // ceil(2^33 / 3), exact floor(x / 3) for any x below 2^32 after >> 33
  localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_INITIAL_STEP = 3'd1,
    CFG_MIN_STEP     = 3'd2,
    CFG_MAX_STEP     = 3'd3,
    CFG_GROW_FACTOR  = 3'd4,
    CFG_DECAY_FACTOR = 3'd5,
    CFG_ZOOM_OFFSET  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_GROW  = 2'd1,
    MODE_ZOOM  = 2'd2
  } mode_e;

  localparam logic [1:0]  RST_MODE         = 2'd1;
  localparam logic [31:0] RST_INITIAL_STEP = 32'd65536;
  localparam logic [31:0] RST_MIN_STEP     = 32'd256;
  localparam logic [31:0] RST_MAX_STEP     = 32'd16777216;
  localparam logic [15:0] RST_GROW_FACTOR  = 16'd6144;
  localparam logic [12:0] RST_DECAY_FACTOR = 13'd2048;
  localparam logic [31:0] RST_ZOOM_OFFSET  = 32'd0;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        init_step;
    logic [31:0]        step_floor;
    logic [31:0]        step_ceil;
    logic [15:0]        rep_gain;
    logic [12:0]        flip_gain;
    logic signed [31:0] zoom_bias;
  } cfg_t;

  typedef struct packed {
    logic have_last;
    logic last_code;
    logic win_full;
    logic win_uniform;
  } hist_t;

endpackage

`default_nettype wire

@@ design/ads_cfg_regs.sv @@
// configuration register file for the adaptive delta step size block
// depends on ads_pkg
`default_nettype none

module ads_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ads_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ads_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ads_pkg::cfg_t                          cfg_o,
  output logic                                   clear_o,
  output logic [31:0]                            reload_step_o
);

  ads_pkg::cfg_t cfg_q, cfg_d;
  logic          hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ads_pkg::CFG_MODE: begin
          cfg_d.mode = cfg_wdata_i[1:0];
          hit = 1'b1;
        end
        ads_pkg::CFG_INITIAL_STEP: begin
          cfg_d.init_step = cfg_wdata_i;
          hit = 1'b1;
        end
        ads_pkg::CFG_MIN_STEP: begin
          cfg_d.step_floor = cfg_wdata_i;
          hit = 1'b1;
        end
        ads_pkg::CFG_MAX_STEP: begin
          cfg_d.step_ceil = cfg_wdata_i;
          hit = 1'b1;
        end
        ads_pkg::CFG_GROW_FACTOR: begin
          cfg_d.rep_gain = cfg_wdata_i[15:0];
          hit = 1'b1;
        end
        ads_pkg::CFG_DECAY_FACTOR: begin
          cfg_d.flip_gain = cfg_wdata_i[12:0];
          hit = 1'b1;
        end
        ads_pkg::CFG_ZOOM_OFFSET: begin
          cfg_d.zoom_bias = $signed(cfg_wdata_i);
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= ads_pkg::RST_MODE;
      cfg_q.init_step  <= ads_pkg::RST_INITIAL_STEP;
      cfg_q.step_floor <= ads_pkg::RST_MIN_STEP;
      cfg_q.step_ceil  <= ads_pkg::RST_MAX_STEP;
      cfg_q.rep_gain   <= ads_pkg::RST_GROW_FACTOR;
      cfg_q.flip_gain  <= ads_pkg::RST_DECAY_FACTOR;
      cfg_q.zoom_bias  <= $signed(ads_pkg::RST_ZOOM_OFFSET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o         = cfg_q;
  assign clear_o       = hit;
  // step reload sees the value being written this cycle
  assign reload_step_o = cfg_d.init_step;

endmodule

`default_nettype wire

@@ design/ads_history.sv @@
// code history: previous code for grow mode, three-code window for zoom mode
// depends on ads_pkg
`default_nettype none

module ads_history (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        clear_i,
  input  wire logic        advance_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic        code_i,
  output ads_pkg::hist_t   hist_o
);

  logic                                 last_code_q, last_code_d;
  logic                                 have_last_q, have_last_d;
  logic [ads_pkg::WINDOW_LENGTH-1:0]    window_q, window_d, window_new;
  logic [1:0]                           slot_q, slot_d;
  logic [1:0]                           fill_q, fill_d, fill_inc;

  always_comb begin
    for (int i = 0; i < ads_pkg::WINDOW_LENGTH; i++) begin
      window_new[i] = (slot_q == 2'(i)) ? code_i : window_q[i];
    end
  end

  assign fill_inc = (fill_q == 2'(ads_pkg::WINDOW_LENGTH)) ? fill_q : fill_q + 2'd1;

  always_comb begin
    last_code_d = last_code_q;
    have_last_d = have_last_q;
    window_d    = window_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    if (clear_i) begin
      last_code_d = 1'b0;
      have_last_d = 1'b0;
      window_d    = '0;
      slot_d      = '0;
      fill_d      = '0;
    end else if (advance_i) begin
      if (mode_i == ads_pkg::MODE_ZOOM) begin
        window_d = window_new;
        slot_d   = (slot_q == 2'(ads_pkg::WINDOW_LENGTH - 1)) ? 2'd0 : slot_q + 2'd1;
        fill_d   = fill_inc;
      end else begin
        last_code_d = code_i;
        have_last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q <= 1'b0;
      have_last_q <= 1'b0;
      window_q    <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
    end else begin
      last_code_q <= last_code_d;
      have_last_q <= have_last_d;
      window_q    <= window_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
    end
  end

  assign hist_o.have_last   = have_last_q;
  assign hist_o.last_code   = last_code_q;
  assign hist_o.win_full    = (fill_inc == 2'(ads_pkg::WINDOW_LENGTH));
  assign hist_o.win_uniform = (&window_new) | ~(|window_new);

endmodule

`default_nettype wire

@@ design/ads_step_calc.sv @@
// next step datapath: shared multiplier, zoom scaling, offset add and clamp
// depends on ads_pkg
`default_nettype none

module ads_step_calc (
  input  wire ads_pkg::cfg_t   cfg_i,
  input  wire ads_pkg::hist_t  hist_i,
  input  wire logic            code_i,
  input  wire logic [31:0]     step_i,
  output logic [31:0]          step_o,
  output logic                 ready_o
);

  logic               is_grow;
  logic [15:0]        factor;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [35:0]        grow_val;
  logic [29:0]        quot6;
  logic [31:0]        six_q;
  logic [2:0]         rem6;
  logic [32:0]        five_q;
  logic [32:0]        scaled_5_6, scaled_3_2, scaled;
  logic [33:0]        triple;
  logic signed [34:0] zoom_val;
  logic signed [36:0] grow_c, zoom_c, min_c, max_c;
  logic [31:0]        grow_clamp, zoom_clamp;

  assign is_grow = (cfg_i.mode == ads_pkg::MODE_GROW);
  assign factor  = (code_i == hist_i.last_code) ? cfg_i.rep_gain
                                                : {3'b0, cfg_i.flip_gain};

  // one multiplier: step * factor in grow mode, (step / 2) * 1/3 in zoom mode
  assign mul_a = is_grow ? step_i : {1'b0, step_i[31:1]};
  assign mul_b = is_grow ? {16'b0, factor} : ads_pkg::RECIP_3;
  assign prod  = 64'(mul_a) * 64'(mul_b);

  assign grow_val = prod[47:12];

  // floor(5s/6) = 5q + floor(5r/6) with s = 6q + r
  assign quot6      = prod[62:33];
  assign six_q      = {quot6, 2'b0} + {1'b0, quot6, 1'b0};
  assign rem6       = 3'(step_i - six_q);
  assign five_q     = {1'b0, quot6, 2'b0} + {3'b0, quot6};
  assign scaled_5_6 = five_q + ((rem6 == 3'd0) ? 33'd0 : 33'(rem6 - 3'd1));

  assign triple     = {1'b0, step_i, 1'b0} + {2'b0, step_i};
  assign scaled_3_2 = triple[33:1];

  assign scaled   = hist_i.win_uniform ? scaled_3_2 : scaled_5_6;
  assign zoom_val = $signed({2'b0, scaled})
                  + $signed({{3{cfg_i.zoom_bias[31]}}, cfg_i.zoom_bias});

  assign grow_c = $signed({1'b0, grow_val});
  assign zoom_c = $signed({{2{zoom_val[34]}}, zoom_val});
  assign min_c  = $signed({5'b0, cfg_i.step_floor});
  assign max_c  = $signed({5'b0, cfg_i.step_ceil});

  // low side first, so when the bounds cross a value below min gets min even if it is above max
  assign grow_clamp = (grow_c < min_c) ? cfg_i.step_floor :
                      (grow_c > max_c) ? cfg_i.step_ceil : grow_val[31:0];
  assign zoom_clamp = (zoom_c < min_c) ? cfg_i.step_floor :
                      (zoom_c > max_c) ? cfg_i.step_ceil : zoom_c[31:0];

  always_comb begin
    step_o  = step_i;
    ready_o = 1'b0;
    case (cfg_i.mode)
      ads_pkg::MODE_GROW: begin
        if (hist_i.have_last) begin
          step_o  = grow_clamp;
          ready_o = 1'b1;
        end
      end
      ads_pkg::MODE_ZOOM: begin
        if (hist_i.win_full) begin
          step_o  = zoom_clamp;
          ready_o = 1'b1;
        end
      end
      default: begin
        step_o  = step_i;
        ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/adaptive_delta_step_size.sv @@
// Adaptive delta-modulation step size. Each input beat carries one code bit
// (1 = +1, 0 = -1); each accepted beat yields one output beat with the updated
// unsigned Q16.16 step and a flag telling whether the mode had enough history
// to adapt. The multiply, offset add and clamp run while the beat sits in the
// input register, and the result lands in the output register, together with
// the step state. A new beat is taken every cycle unless in_stall_o is high;
// the rate is set by the single step feedback loop (32x32 multiplier and
// clamp) running from the step register back to itself. While a result waits
// under out_stall_i the held beat stays in the input register, so at most two
// beats are inside, and in_stall_o rises only when both registers are full and
// the output is stalled. Configuration writes are taken at any edge with
// cfg_we_i high and belong between beats, with nothing in flight; a write to an
// index in the register list reloads the step and clears the history.
// Depends on ads_pkg, ads_cfg_regs, ads_history, ads_step_calc.
`default_nettype none

`include "adaptive_delta_step_size_assert.svh"

module adaptive_delta_step_size (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [ads_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ads_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // code beats in
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            code_bit_i,
  // step beats out
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [31:0]                          step_size_o,
  output logic                                 history_ready_o
);

  ads_pkg::cfg_t  cfg;
  ads_pkg::hist_t hist;
  logic           clear;
  logic [31:0]    reload_step;

  logic           in_valid_q, in_valid_d;
  logic           code_q;
  logic           advance, accept;
  logic [31:0]    step_q, step_d, step_next;
  logic           ready_next;
  logic           out_valid_q, out_valid_d;
  logic [31:0]    out_step_q;
  logic           out_ready_q;

  // the held beat moves on when the output register is empty or emptying
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  ads_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cfg_o         (cfg),
    .clear_o       (clear),
    .reload_step_o (reload_step)
  );

  ads_history u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .advance_i (advance),
    .mode_i    (cfg.mode),
    .code_i    (code_q),
    .hist_o    (hist)
  );

  ads_step_calc u_calc (
    .cfg_i   (cfg),
    .hist_i  (hist),
    .code_i  (code_q),
    .step_i  (step_q),
    .step_o  (step_next),
    .ready_o (ready_next)
  );

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // step state: a config write to a listed index reloads, otherwise each beat updates it
  always_comb begin
    step_d = step_q;
    if (clear) begin
      step_d = reload_step;
    end else if (advance) begin
      step_d = step_next;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= ads_pkg::RST_INITIAL_STEP;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q <= code_bit_i;
    end
    if (advance) begin
      out_step_q  <= step_next;
      out_ready_q <= ready_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_size_o     = out_step_q;
  assign history_ready_o = out_ready_q;

  // a stall is only raised while a beat is held
  `ADS_ASSERT_NOW(a_stall_needs_beat, in_stall_o, in_valid_q, "stall without a held beat")
  // a result waiting on the output is never dropped
  `ADS_ASSERT_NEXT(a_out_kept, out_valid_q && out_stall_i, out_valid_q, "waiting result lost")
  // a config write leaves no history behind and reloads the step
  `ADS_ASSERT_NEXT(a_clear_history, clear, !hist.have_last && step_q == cfg.init_step, "history not cleared")

endmodule

`default_nettype wire
